FILE: rtl/lsc_pkg.sv
// Shared types, constants and the arctangent table of the laser scan cell classifier.
// No dependencies; every other file of the block imports it.
package lsc_pkg;

  localparam int GRID_SIDE_DEF = 64;
  localparam int BEAMS         = 181;
  localparam int LAST_BEAM     = 180;
  localparam int CORDIC_STEPS  = 16;
  localparam int PRESCALE_SH   = 20;
  localparam int ZW            = 26;
  localparam int QUEUE_DEPTH   = 32;

  localparam logic [ZW-1:0] Z_QUARTER  = ZW'(90 * 65536);
  localparam logic [ZW-1:0] Z_HALF_DEG = ZW'(32768);
  localparam logic [11:0]   CELL_SIZE_RST = 12'd469;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_FREE    = 2'd1,
    CLS_WALL    = 2'd2
  } cls_t;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  beam_index;
    logic [14:0] beam_range;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
  } lsc_item_t;

  typedef struct packed {
    logic [1:0] cell_class;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
  } lsc_res_t;

  // Width of a signed cell offset; the 6-bit cell ports reach past a small grid
  function automatic int off_width(input int grid);
    int gw;
    gw = $clog2(grid);
    return ((gw > 6) ? gw : 6) + 2;
  endfunction

  // Arctangent of 2^-i in degrees, Q16.16
  function automatic logic [ZW-1:0] atan_q16(input int idx);
    case (idx)
      0:       return ZW'(2949120);
      1:       return ZW'(1740967);
      2:       return ZW'(919879);
      3:       return ZW'(466945);
      4:       return ZW'(234379);
      5:       return ZW'(117304);
      6:       return ZW'(58666);
      7:       return ZW'(29335);
      8:       return ZW'(14668);
      9:       return ZW'(7334);
      10:      return ZW'(3667);
      11:      return ZW'(1833);
      12:      return ZW'(917);
      13:      return ZW'(458);
      14:      return ZW'(229);
      15:      return ZW'(115);
      default: return '0;
    endcase
  endfunction

endpackage

FILE: rtl/laser_scan_cell_classifier_unit.sv
// Top level of the laser scan cell classifier: bearing pipeline, scan store, result queue.
// Depends on lsc_pkg, lsc_bearing, lsc_classify and lsc_queue.
//
// Usage:
//   Input side is a queue: drive the in_ fields and raise push; the item is taken on an
//   edge where full is low. A beam write (in_req_type 0) stores in_beam_range at
//   in_beam_index and gives no result; a query (in_req_type 1) yields one result.
//   Result side is a queue: while empty is low the oldest result sits on out_cell_class,
//   out_x, out_y; raise pop to take it.
//   cfg_wr_en writes cell_size from cfg_wr_data at once; write it only while idle.
// Timing:
//   One item per cycle is accepted while full is low. A query result passes the entry
//   stage, sixteen CORDIC stages, store read and squaring stage to the queue. Writes follow the
//   same path, so every query sees exactly the beams written before it.
//   The queue holds 32 results and full rises when queued plus in-flight queries reach
//   that count, so a stalled receiver stops the input side without losing anything.
// Reset:
//   Clears the pipeline valids, the queue and the credit count and sets cell_size to 469.
//   The scan store is not cleared; a beam must be written before it is queried.
module laser_scan_cell_classifier_unit import lsc_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int DEPTH     = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic [7:0]  in_beam_index,
  input  logic [14:0] in_beam_range,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_cell_class,
  output logic [5:0]  out_x,
  output logic [5:0]  out_y,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data
);

  localparam int UW = off_width(GRID_SIDE);

  logic [11:0] cell_size_r;
  logic        accept;
  lsc_item_t   item;

  // Hold the cell size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= CELL_SIZE_RST;
    end else if (cfg_wr_en) begin
      cell_size_r <= cfg_wr_data;
    end
  end

  assign accept = push && !full;

  always_comb begin
    item.req_type   = in_req_type;
    item.beam_index = in_beam_index;
    item.beam_range = in_beam_range;
    item.cell_x     = in_cell_x;
    item.cell_y     = in_cell_y;
  end

  logic                 b_valid;
  lsc_item_t            b_item;
  logic signed [UW-1:0] b_ux, b_uy;
  logic                 b_hit;
  logic [7:0]           b_addr;

  lsc_bearing #(.GRID_SIDE(GRID_SIDE)) u_bearing (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_item   (item),
    .out_valid (b_valid),
    .out_item  (b_item),
    .out_ux    (b_ux),
    .out_uy    (b_uy),
    .out_hit   (b_hit),
    .out_addr  (b_addr)
  );

  logic     r_valid;
  lsc_res_t r_data;

  lsc_classify #(.GRID_SIDE(GRID_SIDE)) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .cell_size (cell_size_r),
    .in_valid  (b_valid),
    .in_item   (b_item),
    .in_ux     (b_ux),
    .in_uy     (b_uy),
    .in_hit    (b_hit),
    .in_addr   (b_addr),
    .res_valid (r_valid),
    .res       (r_data)
  );

  lsc_res_t q_data;

  lsc_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (accept && in_req_type == REQ_QUERY),
    .full      (full),
    .push      (r_valid),
    .push_data (r_data),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (q_data)
  );

  assign out_cell_class = q_data.cell_class;
  assign out_x          = q_data.cell_x;
  assign out_y          = q_data.cell_y;

endmodule

FILE: rtl/lsc_bearing.sv
// Front end: cell offsets and a 16-stage vectoring CORDIC pipeline giving the beam bearing.
// Depends on lsc_pkg.
module lsc_bearing import lsc_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  lsc_item_t                              in_item,
  output logic                                   out_valid,
  output lsc_item_t                              out_item,
  output logic signed [off_width(GRID_SIDE)-1:0] out_ux,
  output logic signed [off_width(GRID_SIDE)-1:0] out_uy,
  output logic                                   out_hit,
  output logic [7:0]                             out_addr
);

  localparam int UW = off_width(GRID_SIDE);
  localparam int XW = UW + PRESCALE_SH + 2;
  localparam int DW = ZW - 16;

  logic                 v_r    [0:CORDIC_STEPS];
  lsc_item_t            item_r [0:CORDIC_STEPS];
  logic signed [UW-1:0] ux_r   [0:CORDIC_STEPS];
  logic signed [UW-1:0] uy_r   [0:CORDIC_STEPS];
  logic signed [XW-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [XW-1:0] y_r    [0:CORDIC_STEPS];
  logic signed [ZW-1:0] z_r    [0:CORDIC_STEPS];

  logic signed [UW-1:0] ux0, uy0;
  logic signed [XW-1:0] uxw, uyw;

  // Offsets from the sensor cell
  assign ux0 = $signed(UW'(in_item.cell_x)) - $signed(UW'(GRID_SIDE / 2));
  assign uy0 = $signed(UW'(GRID_SIDE - 1)) - $signed(UW'(in_item.cell_y));
  assign uxw = {{(XW-UW){ux0[UW-1]}}, ux0};
  assign uyw = {{(XW-UW){uy0[UW-1]}}, uy0};

  // Entry stage: prescale, pre-rotate left half-plane by a quarter turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r[0] <= in_item;
    ux_r[0]   <= ux0;
    uy_r[0]   <= uy0;
    if (ux0 < 0) begin
      x_r[0] <= uyw <<< PRESCALE_SH;
      y_r[0] <= (-uxw) <<< PRESCALE_SH;
      z_r[0] <= $signed(Z_QUARTER);
    end else begin
      x_r[0] <= uxw <<< PRESCALE_SH;
      y_r[0] <= uyw <<< PRESCALE_SH;
      z_r[0] <= '0;
    end
  end

  // Micro-rotation stages, one shift distance each
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] xsh, ysh;
    assign xsh = x_r[i] >>> i;
    assign ysh = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      item_r[i+1] <= item_r[i];
      ux_r[i+1]   <= ux_r[i];
      uy_r[i+1]   <= uy_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + ysh;
        y_r[i+1] <= y_r[i] - xsh;
        z_r[i+1] <= z_r[i] + $signed(atan_q16(i));
      end else begin
        x_r[i+1] <= x_r[i] - ysh;
        y_r[i+1] <= y_r[i] + xsh;
        z_r[i+1] <= z_r[i] - $signed(atan_q16(i));
      end
    end
  end

  // Round the angle to whole degrees and pick the beam
  logic signed [ZW-1:0] zl, zr;
  logic [DW-1:0]        deg;

  assign zl  = z_r[CORDIC_STEPS];
  assign zr  = zl + $signed(Z_HALF_DEG);
  assign deg = zr[ZW-1:16];

  always_comb begin
    out_hit  = 1'b0;
    out_addr = '0;
    if (uy_r[CORDIC_STEPS] < 0) begin
      out_hit = 1'b0;
    end else if (uy_r[CORDIC_STEPS] == 0) begin
      // on the sensor line: straight left reads beam zero, right or centre is unknown
      out_hit = ux_r[CORDIC_STEPS] < 0;
    end else if (zl < 0) begin
      out_hit = 1'b0;
    end else if (deg >= DW'(1) && deg <= DW'(LAST_BEAM)) begin
      out_hit  = 1'b1;
      out_addr = 8'(DW'(LAST_BEAM) - deg);
    end
  end

  assign out_valid = v_r[CORDIC_STEPS];
  assign out_item  = item_r[CORDIC_STEPS];
  assign out_ux    = ux_r[CORDIC_STEPS];
  assign out_uy    = uy_r[CORDIC_STEPS];

endmodule

FILE: rtl/lsc_classify.sv
// Scan store and range comparison: beam writes land here in order, queries read and classify.
// Depends on lsc_pkg.
module lsc_classify import lsc_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [11:0]                            cell_size,
  input  logic                                   in_valid,
  input  lsc_item_t                              in_item,
  input  logic signed [off_width(GRID_SIDE)-1:0] in_ux,
  input  logic signed [off_width(GRID_SIDE)-1:0] in_uy,
  input  logic                                   in_hit,
  input  logic [7:0]                             in_addr,
  output logic                                   res_valid,
  output lsc_res_t                               res
);

  localparam int UW  = off_width(GRID_SIDE);
  localparam int MW  = UW - 1;
  localparam int DW  = MW + 12;
  localparam int SW  = 2 * DW;
  localparam int D4W = SW + 3;

  logic [14:0] scan_mem [0:BEAMS-1];

  // Stage M: store access and cell distances in millimetres
  logic [UW-1:0] nux, nuy;
  logic [MW-1:0] mag_x, mag_y;

  assign nux   = -in_ux;
  assign nuy   = -in_uy;
  assign mag_x = in_ux[UW-1] ? nux[MW-1:0] : in_ux[MW-1:0];
  assign mag_y = in_uy[UW-1] ? nuy[MW-1:0] : in_uy[MW-1:0];

  logic          m_valid_r;
  logic          m_hit_r;
  logic [5:0]    m_x_r, m_y_r;
  logic [14:0]   rd_r;
  logic [DW-1:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_item.req_type == REQ_WRITE && in_item.beam_index < 8'(BEAMS)) begin
      scan_mem[in_item.beam_index] <= in_item.beam_range;
    end
    rd_r <= scan_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= in_valid && in_item.req_type == REQ_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    m_hit_r <= in_hit;
    m_x_r   <= in_item.cell_x;
    m_y_r   <= in_item.cell_y;
    dx_r    <= DW'(mag_x) * DW'(cell_size);
    dy_r    <= DW'(mag_y) * DW'(cell_size);
  end

  // Stage C: squares of distance and of the tolerance bounds
  logic [16:0]        hi;
  logic signed [17:0] lo;
  logic [16:0]        lo_mag;

  assign hi     = {1'b0, rd_r, 1'b0} + 17'(cell_size);
  assign lo     = $signed({2'b00, rd_r, 1'b0}) - $signed(18'(cell_size));
  assign lo_mag = lo[16:0];

  logic          c_valid_r;
  logic          c_hit_r;
  logic          c_lo_pos_r;
  logic [5:0]    c_x_r, c_y_r;
  logic [33:0]   hi2_r, lo2_r;
  logic [SW-1:0] dx2_r, dy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    c_hit_r    <= m_hit_r;
    c_lo_pos_r <= lo > 0;
    c_x_r      <= m_x_r;
    c_y_r      <= m_y_r;
    hi2_r      <= 34'(hi) * 34'(hi);
    lo2_r      <= 34'(lo_mag) * 34'(lo_mag);
    dx2_r      <= SW'(dx_r) * SW'(dx_r);
    dy2_r      <= SW'(dy_r) * SW'(dy_r);
  end

  // Compare against four times the squared distance
  logic [D4W-1:0] d4;
  cls_t           cls;

  assign d4 = (D4W'(dx2_r) + D4W'(dy2_r)) << 2;

  always_comb begin
    if (!c_hit_r) begin
      cls = CLS_UNKNOWN;
    end else if (D4W'(hi2_r) <= d4) begin
      cls = CLS_UNKNOWN;
    end else if (c_lo_pos_r && D4W'(lo2_r) > d4) begin
      cls = CLS_FREE;
    end else begin
      cls = CLS_WALL;
    end
  end

  assign res_valid      = c_valid_r;
  assign res.cell_class = cls;
  assign res.cell_x     = c_x_r;
  assign res.cell_y     = c_y_r;

endmodule

FILE: rtl/lsc_queue.sv
// Result queue with a credit count covering results still in the pipeline.
// Depends on lsc_pkg.
module lsc_queue import lsc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     reserve,
  output logic     full,
  input  logic     push,
  input  lsc_res_t push_data,
  input  logic     pop,
  output logic     empty,
  output lsc_res_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lsc_res_t      buf_r [0:DEPTH-1];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] credit_r, credit_nxt;
  logic          do_pop;

  assign do_pop = pop && !empty;
  assign empty  = count_r == '0;
  assign full   = credit_r == CW'(DEPTH);

  // Track stored results and all results promised to accepted queries
  always_comb begin
    count_nxt  = count_r + CW'(push) - CW'(do_pop);
    credit_nxt = credit_r + CW'(reserve) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      credit_r <= '0;
    end else begin
      count_r  <= count_nxt;
      credit_r <= credit_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = buf_r[rd_ptr_r];

endmodule

FILE: rtl/lsc_checker.sv
// Port-level checks for the laser scan cell classifier, bound to the top level.
// Depends on lsc_pkg and laser_scan_cell_classifier_unit.
module lsc_checker import lsc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_cell_class,
  input logic [5:0]  out_x,
  input logic [5:0]  out_y
);

  // Queue comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Class code is always one of the three defined values
  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_cell_class == CLS_UNKNOWN || out_cell_class == CLS_FREE ||
                out_cell_class == CLS_WALL))
    else $error("undefined cell class on output");

  // Credits are only returned by a pop, so full holds until one is taken
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> full)
    else $error("full dropped without a pop");

  // A waiting result stays put until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_cell_class) && $stable(out_x) && $stable(out_y))
    else $error("waiting result changed before pop");

endmodule

bind laser_scan_cell_classifier_unit lsc_checker u_lsc_checker (.*);

FILE: dv/laser_scan_cell_classifier_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for laser_scan_cell_classifier_unit: beam writes and cell queries
// against an in-bench CORDIC bearing and range-band classifier. Depends on lsc_pkg.
module laser_scan_cell_classifier_unit_tb;
  import lsc_pkg::*;

  localparam int  SIDE        = 64;
  localparam int  SETTLE      = 30;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  N_PHASES    = 5;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_beam_index = '0;
  logic [14:0] in_beam_range = '0;
  logic [5:0]  in_cell_x = '0;
  logic [5:0]  in_cell_y = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_cell_class;
  logic [5:0]  out_x;
  logic [5:0]  out_y;
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;

  laser_scan_cell_classifier_unit dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_req_type(in_req_type), .in_beam_index(in_beam_index),
    .in_beam_range(in_beam_range), .in_cell_x(in_cell_x), .in_cell_y(in_cell_y),
    .empty(empty), .pop(pop),
    .out_cell_class(out_cell_class), .out_x(out_x), .out_y(out_y),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // Arctangent of 2^-i in degrees, Q16.16
  const longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                                 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  lsc_item_t   pending_beats[$];
  lsc_res_t    expected_cells[$];
  logic [14:0] scan_mm[BEAMS];
  logic [11:0] cell_mm = CELL_SIZE_RST;
  bit          beam_known[BEAMS];
  int          send_idle = 0;
  int          recv_idle = 0;
  int          errors = 0;
  int          cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bearing in whole degrees, -1 below the sensor line
  function automatic int bearing_of(input longint ux, input longint uy);
    longint x, y, z, nx;
    if (uy < 0) return -1;
    if (uy == 0) return (ux < 0) ? 180 : 0;
    if (ux < 0) begin
      x = uy <<< 20;
      y = (-ux) <<< 20;
      z = 90 * 65536;
    end else begin
      x = ux <<< 20;
      y = uy <<< 20;
      z = 0;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_deg[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_deg[i];
      end
      x = nx;
    end
    if (z < 0) return 0;
    return int'((z + 32768) >>> 16);
  endfunction

  // Apply one accepted beat to the scan copy, or classify a queried cell
  function automatic void absorb_beat(input lsc_item_t it);
    longint ux, uy, dx, dy, d4, hi, lo, r, cs;
    int deg;
    lsc_res_t res;
    if (it.req_type == REQ_WRITE) begin
      if (it.beam_index <= LAST_BEAM) scan_mm[it.beam_index] = it.beam_range;
      return;
    end
    ux  = longint'(it.cell_x) - SIDE / 2;
    uy  = SIDE - 1 - longint'(it.cell_y);
    deg = bearing_of(ux, uy);
    res.cell_x = it.cell_x;
    res.cell_y = it.cell_y;
    res.cell_class = CLS_UNKNOWN;
    if (deg >= 1 && deg <= 180) begin
      r  = scan_mm[LAST_BEAM - deg];
      cs = cell_mm;
      dx = ux * cs;
      dy = uy * cs;
      d4 = 4 * (dx * dx + dy * dy);
      hi = 2 * r + cs;
      lo = 2 * r - cs;
      if (hi * hi <= d4) res.cell_class = CLS_UNKNOWN;
      else if (lo > 0 && lo * lo > d4) res.cell_class = CLS_FREE;
      else res.cell_class = CLS_WALL;
    end
    expected_cells.push_back(res);
  endfunction

  function automatic void queue_write(input int idx, input int mm);
    lsc_item_t it;
    it = '0;
    it.req_type = REQ_WRITE;
    it.beam_index = idx[7:0];
    it.beam_range = mm[14:0];
    it.cell_x = 6'($urandom);
    it.cell_y = 6'($urandom);
    if (idx <= LAST_BEAM) beam_known[idx] = 1'b1;
    pending_beats.push_back(it);
  endfunction

  // Queue a query; write its beam first if never written or at random, mostly near the cell distance
  function automatic void queue_query(input int cx, input int cy, input int cs);
    lsc_item_t it;
    int deg, mm;
    real cell_dist;
    deg = bearing_of(cx - SIDE / 2, SIDE - 1 - cy);
    if (deg >= 1 && deg <= 180 && (!beam_known[LAST_BEAM - deg] || $urandom_range(3) == 0))
    begin
      cell_dist = $sqrt(real'((cx - SIDE / 2) ** 2 + (SIDE - 1 - cy) ** 2)) * cs;
      mm = int'(cell_dist) + $urandom_range(2 * cs) - cs;
      if ($urandom_range(7) == 0) mm = $urandom_range(32767);
      if (mm < 0) mm = 0;
      if (mm > 32767) mm = 32767;
      queue_write(LAST_BEAM - deg, mm);
    end
    it = '0;
    it.req_type = REQ_QUERY;
    it.beam_index = 8'($urandom);
    it.beam_range = 15'($urandom);
    it.cell_x = cx[5:0];
    it.cell_y = cy[5:0];
    pending_beats.push_back(it);
  endfunction

  // Driver: hold a stalled beat, otherwise advance or idle
  always @(posedge clk) begin
    lsc_item_t it;
    if (rst_n) begin
      if (push && !full) absorb_beat({in_req_type, in_beam_index, in_beam_range,
                                      in_cell_x, in_cell_y});
      if (!(push && full)) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
          it = pending_beats.pop_front();
          push          <= 1'b1;
          in_req_type   <= it.req_type;
          in_beam_index <= it.beam_index;
          in_beam_range <= it.beam_range;
          in_cell_x     <= it.cell_x;
          in_cell_y     <= it.cell_y;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation
  always @(posedge clk) begin
    lsc_res_t e;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_cells.size() == 0) begin
          $display("%0t unexpected result: expected none, actual class %0d x %0d y %0d",
                   $time, out_cell_class, out_x, out_y);
          errors++;
        end else begin
          e = expected_cells.pop_front();
          if (out_cell_class !== e.cell_class) begin
            $display("%0t cell_class mismatch: expected %0d actual %0d (x %0d y %0d)",
                     $time, e.cell_class, out_cell_class, e.cell_x, e.cell_y);
            errors++;
          end
          if (out_x !== e.cell_x) begin
            $display("%0t out_x mismatch: expected %0d actual %0d", $time, e.cell_x, out_x);
            errors++;
          end
          if (out_y !== e.cell_y) begin
            $display("%0t out_y mismatch: expected %0d actual %0d", $time, e.cell_y, out_y);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL laser_scan_cell_classifier_unit");
      $finish;
    end
  end

  task automatic drain_and_settle();
    while (pending_beats.size() > 0 || push || expected_cells.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int sizes[N_PHASES];
    int cs;
    sizes = '{469, 1, 4095, 0, 0};
    sizes[3] = $urandom_range(4095, 1);
    sizes[4] = $urandom_range(300, 20);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < N_PHASES; ph++) begin
      cs = sizes[ph];
      send_idle = (ph < 2) ? 8 : (ph < 4) ? 86 : 0;
      recv_idle = (ph < 2) ? 86 : (ph < 4) ? 8 : 0;
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= cs[11:0];
      @(posedge clk);
      cell_mm = cs[11:0];
      cfg_wr_en <= 1'b0;
      if (ph == 0) begin
        // Extremes: range limits, last beam, out-of-range beam, grid corners, sensor cell
        queue_write(0, 32767);
        queue_write(LAST_BEAM, 0);
        queue_write(255, 12345);
        queue_write(181, 1);
        queue_query(0, 63, cs);
        queue_query(63, 63, cs);
        queue_query(32, 63, cs);
        queue_query(0, 0, cs);
        queue_query(63, 0, cs);
        queue_query(32, 0, cs);
        queue_query(31, 62, cs);
        queue_query(33, 62, cs);
        queue_query(31, 63, cs);
        queue_write(90, 0);
        queue_query(32, 62, cs);
        queue_query(32, 60, cs);
      end
      for (int n = 0; n < 90; n++) begin
        if ($urandom_range(4) == 0)
          queue_write($urandom_range(255), $urandom_range(32767));
        else
          queue_query($urandom_range(63), $urandom_range(63), cs);
      end
      drain_and_settle();
    end
    if (errors == 0 && expected_cells.size() == 0) begin
      $display("PASS laser_scan_cell_classifier_unit");
    end else begin
      $display("FAIL laser_scan_cell_classifier_unit");
    end
    $finish;
  end

endmodule
